/* rtl/gsv_pkg.sv */
// Shared types and byte range constants for the GB18030 sequence validator.
package gsv_pkg;

  // Byte range limits used by the sequence rules.
  localparam logic [7:0] ByteAsciiMax   = 8'h7F;
  localparam logic [7:0] ByteLeadBad    = 8'h80;
  localparam logic [7:0] ByteLeadMin    = 8'h81;
  localparam logic [7:0] ByteLeadMax    = 8'hFE;
  localparam logic [7:0] ByteFF         = 8'hFF;
  localparam logic [7:0] ByteTrailMin   = 8'h40;
  localparam logic [7:0] ByteDigitMin   = 8'h30;
  localparam logic [7:0] ByteDigitMax   = 8'h39;
  localparam logic [7:0] ByteFourLoMax  = 8'h84;
  localparam logic [7:0] ByteFourHiMin  = 8'h90;
  localparam logic [7:0] ByteFourHiMax  = 8'hE3;
  localparam logic [7:0] ByteEscape     = 8'h1B;
  localparam logic [7:0] ByteCtrlMin    = 8'h08;
  localparam logic [7:0] ByteCtrlMax    = 8'h0D;
  localparam logic [7:0] BytePrintMin   = 8'h20;
  localparam logic [7:0] BytePrintMax   = 8'h7E;

  // Held sequence depth and width of the held byte count.
  localparam int unsigned HeldDepth = 3;
  localparam int unsigned CountW    = 2;

  // Per-word result code.
  typedef enum logic [1:0] {
    StNeedMore = 2'd0,
    StValid    = 2'd1,
    StNonText  = 2'd2,
    StInvalid  = 2'd3
  } status_e;

  // Decoder result for one word.
  typedef struct packed {
    status_e     status;
    logic [2:0]  char_length;
    logic [31:0] char_bytes;
    logic        char_done;
    logic        hold;
  } dec_res_t;

endpackage

/* rtl/gsv_decode.sv */
// Combinational rule check of one byte against the sequence held so far.
module gsv_decode (
  input  logic [7:0]                          byte_i,
  input  logic [gsv_pkg::CountW-1:0]          held_count_i,
  input  logic [gsv_pkg::HeldDepth-1:0][7:0]  held_bytes_i,
  output gsv_pkg::dec_res_t                   res_o
);
  import gsv_pkg::*;

  logic is_digit;
  logic is_text;
  logic is_trail2;
  logic is_lead;
  logic lead_four;

  // Range classification of the incoming byte and the held lead byte.
  assign is_digit  = (byte_i >= ByteDigitMin) && (byte_i <= ByteDigitMax);
  assign is_text   = ((byte_i >= ByteCtrlMin) && (byte_i <= ByteCtrlMax)) ||
                     (byte_i == ByteEscape) ||
                     ((byte_i >= BytePrintMin) && (byte_i <= BytePrintMax));
  assign is_trail2 = (byte_i >= ByteTrailMin) && (byte_i <= ByteLeadMax) &&
                     (byte_i != ByteAsciiMax);
  assign is_lead   = (byte_i >= ByteLeadMin) && (byte_i <= ByteLeadMax);
  assign lead_four = ((held_bytes_i[0] >= ByteLeadMin) &&
                      (held_bytes_i[0] <= ByteFourLoMax)) ||
                     ((held_bytes_i[0] >= ByteFourHiMin) &&
                      (held_bytes_i[0] <= ByteFourHiMax));

  // Status, packing and hold decision per position in the sequence.
  always_comb begin
    res_o             = '0;
    res_o.status      = StInvalid;
    res_o.char_length = {1'b0, held_count_i} + 3'd1;
    case (held_count_i)
      2'd0: begin
        res_o.char_bytes = {24'h0, byte_i};
        if ((byte_i == ByteLeadBad) || (byte_i == ByteFF)) begin
          res_o.status = StInvalid;
        end else if (byte_i <= ByteAsciiMax) begin
          res_o.status = is_text ? StValid : StNonText;
        end else begin
          res_o.status = StNeedMore;
          res_o.hold   = 1'b1;
        end
      end
      2'd1: begin
        res_o.char_bytes = {16'h0, held_bytes_i[0], byte_i};
        if (is_trail2) begin
          res_o.status = StValid;
        end else if (lead_four && is_digit) begin
          res_o.status = StNeedMore;
          res_o.hold   = 1'b1;
        end else begin
          res_o.status = StInvalid;
        end
      end
      2'd2: begin
        res_o.char_bytes = {8'h0, held_bytes_i[0], held_bytes_i[1], byte_i};
        if (is_lead) begin
          res_o.status = StNeedMore;
          res_o.hold   = 1'b1;
        end else begin
          res_o.status = StInvalid;
        end
      end
      default: begin
        res_o.char_bytes = {held_bytes_i[0], held_bytes_i[1], held_bytes_i[2], byte_i};
        res_o.status     = is_digit ? StValid : StInvalid;
      end
    endcase
    res_o.char_done = ~res_o.hold;
  end

endmodule

/* rtl/gb18030_sequence_validator.sv */
// Top level of the GB18030 byte sequence validator: stream ports and registers.
//
// The block takes one text byte per word and returns one result word per byte,
// telling whether more bytes are needed, a valid character was completed, a
// single byte was complete but not text, or the sequence is invalid; tlast
// marks the byte that ends a sequence. It accepts a byte in every cycle unless
// the result register is stalled; each byte passes the input register, then the
// result register. The rate is set by the loop from the held sequence bytes
// through the rule decoder and back.
module gb18030_sequence_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [1:0] status, [4:2] char_length,
                                        // [36:5] char_bytes, [39:37] zero
  output logic        m_axis_tlast_o    // char_done
);
  import gsv_pkg::*;

  logic                     in_valid_q, in_valid_d;
  logic [7:0]               in_byte_q;
  logic                     out_valid_q, out_valid_d;
  dec_res_t                 out_res_q;
  logic [CountW-1:0]        held_count_q, held_count_d;
  logic [HeldDepth-1:0][7:0] held_bytes_q, held_bytes_d;
  logic                     res_ready;
  logic                     advance;
  logic                     in_take;
  dec_res_t                 dec_res;

  // Handshake: each stage refills when its downstream side moves.
  assign res_ready       = ~out_valid_q | m_axis_tready_i;
  assign advance         = in_valid_q & res_ready;
  assign s_axis_tready_o = ~in_valid_q | res_ready;
  assign in_take         = s_axis_tvalid_i & s_axis_tready_o;
  assign in_valid_d      = in_take | (in_valid_q & ~res_ready);
  assign out_valid_d     = advance | (out_valid_q & ~m_axis_tready_i);

  // Rule check of the registered byte.
  gsv_decode u_decode (
    .byte_i       (in_byte_q),
    .held_count_i (held_count_q),
    .held_bytes_i (held_bytes_q),
    .res_o        (dec_res)
  );

  // Next held sequence: append on hold, clear on completion or error.
  always_comb begin
    held_count_d = held_count_q;
    held_bytes_d = held_bytes_q;
    if (advance) begin
      if (dec_res.hold) begin
        held_count_d = held_count_q + 2'd1;
        case (held_count_q)
          2'd0:    held_bytes_d[0] = in_byte_q;
          2'd1:    held_bytes_d[1] = in_byte_q;
          default: held_bytes_d[2] = in_byte_q;
        endcase
      end else begin
        held_count_d = '0;
        held_bytes_d = '0;
      end
    end
  end

  // Control and sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      held_count_q <= '0;
      held_bytes_q <= '0;
    end else begin
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      held_count_q <= held_count_d;
      held_bytes_q <= held_bytes_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_res_q <= dec_res;
    end
  end

  // Result word.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_res_q.char_bytes, out_res_q.char_length,
                            out_res_q.status};
  assign m_axis_tlast_o  = out_res_q.char_done;

  // A fourth byte always ends the sequence.
  a_four_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (held_count_q == 2'd3)) |=> (held_count_q == 2'd0))
    else $error("sequence not closed after fourth byte");

  // Length reported matches the held count plus the new byte.
  a_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_res_q.char_length == ({1'b0, $past(held_count_q)} + 3'd1)))
    else $error("char_length does not follow held count");

  // A result without tlast is always a need-more status.
  a_open_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.char_done) |-> (out_res_q.status == StNeedMore))
    else $error("open sequence with final status");

  // A held sequence always starts with a multi-byte lead.
  a_held_lead : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_count_q != 2'd0) |->
      ((held_bytes_q[0] >= ByteLeadMin) && (held_bytes_q[0] <= ByteLeadMax)))
    else $error("held sequence without a lead byte");

endmodule

/* verif/gb18030_sequence_validator_tb.sv */
// Self-checking testbench for the GB18030 byte sequence validator stream block.
`timescale 1ns / 100ps

module gb18030_sequence_validator_tb;
  import gsv_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RxStallLen    = 300;
  localparam int unsigned RxStallAt     = 850;
  localparam int unsigned PhaseItems    = 350;
  localparam int unsigned TailCycles    = 8;

  // One expected result word of the validator.
  typedef struct {
    status_e     status;
    logic [2:0]  char_length;
    logic [31:0] char_bytes;
    logic        char_done;
  } char_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  // Bytes waiting to be offered and results waiting to be seen.
  logic [7:0]   pending_bytes[$];
  char_result_t expected_results[$];

  // Predictor copy of the sequence in progress.
  logic [7:0] seq_held[3] = '{default: 8'h00};
  logic [1:0] seq_count = 2'd0;

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 71;
  int unsigned bytes_queued = 0;
  int unsigned bytes_in = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned status_seen[4] = '{default: 0};
  int unsigned rx_stall_left = 0;
  logic        rx_stall_done = 1'b0;
  logic        byte_taken = 1'b0;

  gb18030_sequence_validator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] in_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [1:0] status, [4:2] char_length,
                                         // [36:5] char_bytes, [39:37] zero
    .m_axis_tlast_o  (m_axis_tlast_o)    // char_done
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic is_digit(input logic [7:0] b);
    return b >= ByteDigitMin && b <= ByteDigitMax;
  endfunction

  // Works out the result of one byte and advances the held sequence.
  function automatic char_result_t gb_predict(input logic [7:0] b);
    char_result_t r;
    logic [31:0]  seq_word;
    logic         hold;
    logic [7:0]   lead;
    seq_word = '0;
    hold = 1'b0;
    lead = seq_held[0];
    for (int i = 0; i < seq_count; i++) begin
      seq_word = {seq_word[23:0], seq_held[i]};
    end
    seq_word = {seq_word[23:0], b};
    case (seq_count)
      2'd0: begin
        if (b == ByteLeadBad || b == ByteFF) begin
          r.status = StInvalid;
        end else if (b <= ByteAsciiMax) begin
          if ((b >= ByteCtrlMin && b <= ByteCtrlMax) || b == ByteEscape ||
              (b >= BytePrintMin && b <= BytePrintMax)) begin
            r.status = StValid;
          end else begin
            r.status = StNonText;
          end
        end else begin
          r.status = StNeedMore;
          hold = 1'b1;
        end
      end
      2'd1: begin
        if (b >= ByteTrailMin && b <= ByteLeadMax && b != ByteAsciiMax) begin
          r.status = StValid;
        end else if (((lead >= ByteLeadMin && lead <= ByteFourLoMax) ||
                      (lead >= ByteFourHiMin && lead <= ByteFourHiMax)) && is_digit(b)) begin
          r.status = StNeedMore;
          hold = 1'b1;
        end else begin
          r.status = StInvalid;
        end
      end
      2'd2: begin
        if (b >= ByteLeadMin && b <= ByteLeadMax) begin
          r.status = StNeedMore;
          hold = 1'b1;
        end else begin
          r.status = StInvalid;
        end
      end
      default: begin
        if (is_digit(b)) begin
          r.status = StValid;
        end else begin
          r.status = StInvalid;
        end
      end
    endcase
    r.char_length = {1'b0, seq_count} + 3'd1;
    r.char_bytes  = seq_word;
    r.char_done   = !hold;
    if (hold) begin
      seq_held[seq_count] = b;
      seq_count = seq_count + 2'd1;
    end else begin
      seq_held = '{default: 8'h00};
      seq_count = 2'd0;
    end
    return r;
  endfunction

  // Sender: offers the next queued byte once the current word has gone.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || byte_taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata_i  <= pending_bytes.pop_front();
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off to fill the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_stall_left != 0) begin
        rx_stall_left   <= rx_stall_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!rx_stall_done && bytes_in >= RxStallAt) begin
        rx_stall_left   <= RxStallLen;
        rx_stall_done   <= 1'b1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: predicts on accepted bytes, checks accepted results, runs the watchdog.
  always @(posedge clk_i) begin
    char_result_t exp_r;
    logic [1:0]   got_status;
    logic [2:0]   got_len;
    logic [31:0]  got_bytes;
    logic [2:0]   got_pad;
    logic         result_taken;
    if (rst_ni) begin
      byte_taken   = s_axis_tvalid_i && s_axis_tready_o;
      result_taken = m_axis_tvalid_o && m_axis_tready_i;
      if (byte_taken) begin
        expected_results.push_back(gb_predict(s_axis_tdata_i));
        bytes_in++;
      end
      if (result_taken) begin
        got_status = m_axis_tdata_o[1:0];
        got_len    = m_axis_tdata_o[4:2];
        got_bytes  = m_axis_tdata_o[36:5];
        got_pad    = m_axis_tdata_o[39:37];
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word: status %0d len %0d bytes %h last %b",
                   $time, got_status, got_len, got_bytes, m_axis_tlast_o);
        end else begin
          exp_r = expected_results.pop_front();
          if (got_status !== exp_r.status || got_len !== exp_r.char_length ||
              got_bytes !== exp_r.char_bytes || m_axis_tlast_o !== exp_r.char_done ||
              got_pad !== 3'b000) begin
            mismatch_count++;
            $display("%0t: mismatch: expected status %0d len %0d bytes %h last %b pad 0",
                     $time, exp_r.status, exp_r.char_length, exp_r.char_bytes,
                     exp_r.char_done);
            $display("%0t:           actual   status %0d len %0d bytes %h last %b pad %b",
                     $time, got_status, got_len, got_bytes, m_axis_tlast_o, got_pad);
          end
        end
        status_seen[got_status]++;
        results_seen++;
      end
      if (byte_taken || result_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, expected_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Holds the stimulus until every queued byte has produced its result.
  task automatic wait_drained();
    while (results_seen != bytes_queued) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Mostly well-formed characters with random content, some noise and broken runs.
  task automatic queue_random(input int unsigned n_items);
    int unsigned target;
    int unsigned kind;
    int unsigned cut;
    logic [7:0]  four_seq[4];
    logic [7:0]  trail;
    target = bytes_queued + n_items;
    while (bytes_queued < target) begin
      kind = $urandom_range(99);
      four_seq[0] = $urandom_range(1) ? 8'($urandom_range(8'h84, 8'h81))
                                      : 8'($urandom_range(8'hE3, 8'h90));
      four_seq[1] = 8'($urandom_range(8'h39, 8'h30));
      four_seq[2] = 8'($urandom_range(8'hFE, 8'h81));
      four_seq[3] = 8'($urandom_range(8'h39, 8'h30));
      if (kind < 20) begin
        push_byte(8'($urandom_range(8'h7F, 8'h00)));
      end else if (kind < 45) begin
        do trail = 8'($urandom_range(8'hFE, 8'h40)); while (trail == ByteAsciiMax);
        push_byte(8'($urandom_range(8'hFE, 8'h81)));
        push_byte(trail);
      end else if (kind < 75) begin
        for (int i = 0; i < 4; i++) push_byte(four_seq[i]);
      end else if (kind < 88) begin
        push_byte(8'($urandom_range(8'hFF, 8'h00)));
      end else begin
        cut = $urandom_range(3, 1);
        for (int i = 0; i < cut; i++) push_byte(four_seq[i]);
        push_byte(8'($urandom_range(8'hFF, 8'h00)));
      end
    end
  endtask

  // Stimulus and phase control.
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: text limits, control bytes, bad leads, two- and four-byte forms,
    // a bad trail, a digit after a two-byte-only lead, and a bad fourth byte.
    push_byte(8'h00); push_byte(8'h08); push_byte(8'h1B); push_byte(8'h1F);
    push_byte(8'h7E); push_byte(8'h7F); push_byte(8'h80); push_byte(8'hFF);
    push_byte(8'h81); push_byte(8'h40);
    push_byte(8'hFE); push_byte(8'hFE);
    push_byte(8'h81); push_byte(8'h7F);
    push_byte(8'hE3); push_byte(8'h39); push_byte(8'hFE); push_byte(8'h30);
    push_byte(8'h85); push_byte(8'h30);
    push_byte(8'h84); push_byte(8'h31); push_byte(8'h81); push_byte(8'h41);
    wait_drained();

    queue_random(PhaseItems);
    wait_drained();

    send_idle_pct = 71;
    recv_idle_pct = 16;
    queue_random(PhaseItems);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(PhaseItems);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    $display("Fed %0d bytes through three back-pressure phases, checked %0d words.",
             bytes_in, results_seen);
    $display("Status mix: need-more %0d, valid %0d, non-text %0d, invalid %0d.",
             status_seen[StNeedMore], status_seen[StValid], status_seen[StNonText],
             status_seen[StInvalid]);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gsv_pkg.sv
rtl/gsv_decode.sv
rtl/gb18030_sequence_validator.sv
verif/gb18030_sequence_validator_tb.sv
